// ===== rtl/stft_pkg.sv =====
// ----------------------------------------------------------------------------
// stft_pkg
// Shared types, constants and twiddle helpers of the spectrogram unit.
// ----------------------------------------------------------------------------
package stft_pkg;

    localparam int FRAME_SIZE_DEF = 64;
    localparam int SMP_W          = 16;
    localparam int WIN_W          = 16;
    localparam int WIN_IDX_W      = 6;
    localparam int WIN_DEPTH      = 64;
    localparam int HOP_W          = 7;
    localparam int CNT_W          = 7;
    localparam int BIN_W          = 6;
    localparam int MAG_W          = 22;
    localparam int TW_W           = 17;
    localparam int V_W            = 18;
    localparam int PROD_W         = 33;
    localparam int TAP_W          = 35;
    localparam int ACC_W          = 42;
    localparam int RND_W          = 25;
    localparam int RAD_W          = 48;
    localparam int ROOT_W         = 24;
    localparam int SQRT_STEPS     = 24;
    localparam int STEP_W         = 5;
    localparam int S_TDATA_W      = 40;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 32;
    localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;
    localparam logic [MAG_W:0]   MAG_MAX   = 23'd4194303;
    localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_SQ,
        S_RAD,
        S_SQRT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             win_we;
        logic             smp_we;
        logic             issue;
        logic             acc_clr;
        logic             sq_load;
        logic             rad_load;
        logic             sqrt_step;
        logic             out_load;
        logic             out_last;
        logic [BIN_W-1:0] bin;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

    function automatic logic signed [TW_W-1:0] q30_to_q15(input logic signed [63:0] s);
        logic signed [63:0] c;
        logic [63:0]        u;
        begin
            c = s;
            if (c < 0) c = 0;
            if (c > 64'sd1073741824) c = 64'sd1073741824;
            u = (64'(c) + 64'd16384) >> 15;
            return TW_W'(u);
        end
    endfunction

    function automatic logic signed [TW_W-1:0] q15_sin(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        begin
            x2 = (x * x) >> 30;
            t  = x;
            s  = $signed(x);
            t = ((t * x2) >> 30) / 6;   s = s - $signed(t);
            t = ((t * x2) >> 30) / 20;  s = s + $signed(t);
            t = ((t * x2) >> 30) / 42;  s = s - $signed(t);
            t = ((t * x2) >> 30) / 72;  s = s + $signed(t);
            t = ((t * x2) >> 30) / 110; s = s - $signed(t);
            t = ((t * x2) >> 30) / 156; s = s + $signed(t);
            t = ((t * x2) >> 30) / 210; s = s - $signed(t);
            return q30_to_q15(s);
        end
    endfunction

    function automatic logic signed [TW_W-1:0] q15_cos(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        begin
            x2 = (x * x) >> 30;
            t  = 64'd1073741824;
            s  = 64'sd1073741824;
            t = ((t * x2) >> 30) / 2;   s = s - $signed(t);
            t = ((t * x2) >> 30) / 12;  s = s + $signed(t);
            t = ((t * x2) >> 30) / 30;  s = s - $signed(t);
            t = ((t * x2) >> 30) / 56;  s = s + $signed(t);
            t = ((t * x2) >> 30) / 90;  s = s - $signed(t);
            t = ((t * x2) >> 30) / 132; s = s + $signed(t);
            t = ((t * x2) >> 30) / 182; s = s - $signed(t);
            return q30_to_q15(s);
        end
    endfunction

endpackage

// ===== rtl/stft_magnitude_spectrogram_unit.sv =====
// ----------------------------------------------------------------------------
// stft_magnitude_spectrogram_unit
// Streaming STFT magnitude: window, real DFT and rounded bin magnitudes.
// ----------------------------------------------------------------------------
// Slave stream: tuser[0] func (0 sample, 1 window write), tuser[1] start_req;
// tdata carries sample, win_index and win_value. Load the window first.
// Master stream: tdata carries bin_index and magnitude, tlast marks the final
// bin (FRAME_SIZE/2) of a frame. Config channel writes hop_size.
// A sample that closes a frame starts FRAME_SIZE/2+1 bins. Each bin passes
// through the taps, the pipeline drain, the square and radicand loads, 24
// root steps and the emit. The taps share the single multiply-accumulate
// pipeline (one tap per cycle) and the root is bit-serial. The slave side
// is not ready while a frame is computed.
// Results leave through one output register; a stalled receiver holds the
// next bin in the root unit and freezes the sequencer until a transaction
// completes. Reset clears frame and hop counts, sets hop_size to 16 and
// empties the output register; memories keep their contents.
// ----------------------------------------------------------------------------
module stft_magnitude_spectrogram_unit #(
    parameter int FRAME_SIZE = stft_pkg::FRAME_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [stft_pkg::S_TDATA_W-1:0] i_s_tdata,  // sample, win_index, win_value
    input  logic [stft_pkg::S_TUSER_W-1:0] i_s_tuser,  // func, start_req
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [stft_pkg::M_TDATA_W-1:0] o_m_tdata,  // bin_index, magnitude
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stft_pkg::HOP_W-1:0]    i_cfg_data
);
    import stft_pkg::*;

    localparam int RW = $clog2(FRAME_SIZE);

    t_cmd          cmd;
    t_sts          sts;
    logic [RW-1:0] n_idx, r_idx;

    stft_ctrl #(.FRAME_SIZE(FRAME_SIZE), .RW(RW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_func      (i_s_tuser[0]),
        .i_start_req (i_s_tuser[1]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_n         (n_idx),
        .o_r         (r_idx)
    );

    stft_dp #(.FRAME_SIZE(FRAME_SIZE), .RW(RW)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_n         (n_idx),
        .i_r         (r_idx),
        .i_sample    (i_s_tdata[15:0]),
        .i_win_index (i_s_tdata[21:16]),
        .i_win_value (i_s_tdata[37:22]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !sts.pipe_busy)
        else $error("input accepted while taps in flight");

    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[BIN_W-1:0] == BIN_W'(FRAME_SIZE / 2)))
        else $error("frame end flagged on wrong bin");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result overwritten before transaction");

endmodule

// ===== rtl/stft_dp.sv =====
// ----------------------------------------------------------------------------
// stft_dp
// Sample and window memories, windowed DFT multiply-accumulate pipeline,
// bit-serial square root and result register.
// ----------------------------------------------------------------------------
module stft_dp #(
    parameter int FRAME_SIZE = stft_pkg::FRAME_SIZE_DEF,
    parameter int RW         = $clog2(FRAME_SIZE)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stft_pkg::t_cmd                i_cmd,
    output stft_pkg::t_sts                o_sts,
    input  logic [RW-1:0]                 i_n,
    input  logic [RW-1:0]                 i_r,
    input  logic [stft_pkg::SMP_W-1:0]    i_sample,
    input  logic [stft_pkg::WIN_IDX_W-1:0] i_win_index,
    input  logic [stft_pkg::WIN_W-1:0]    i_win_value,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [stft_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast
);
    import stft_pkg::*;

    logic signed [TW_W-1:0] cos_tab [FRAME_SIZE];
    logic signed [TW_W-1:0] sin_tab [FRAME_SIZE];

    for (genvar g = 0; g < FRAME_SIZE; g++) begin : g_tw
        localparam int Q   = (4 * g) / FRAME_SIZE;
        localparam int REM = 4 * g - Q * FRAME_SIZE;
        localparam logic [63:0] XQ = (HALF_PI_Q30 * 64'(REM)) / 64'(FRAME_SIZE);
        localparam logic signed [TW_W-1:0] SV = q15_sin(XQ);
        localparam logic signed [TW_W-1:0] CV = q15_cos(XQ);
        localparam logic signed [TW_W-1:0] CT = (Q == 0) ? CV : (Q == 1) ? -SV :
                                                (Q == 2) ? -CV : SV;
        localparam logic signed [TW_W-1:0] ST = (Q == 0) ? SV : (Q == 1) ? CV :
                                                (Q == 2) ? -SV : -CV;
        assign cos_tab[g] = CT;
        assign sin_tab[g] = ST;
    end

    logic [SMP_W-1:0] smp_mem [FRAME_SIZE];
    logic [WIN_W-1:0] win_mem [WIN_DEPTH];

    logic [RW-1:0] r_wp;
    logic [RW:0]   addr_sum;
    logic [RW-1:0] rd_addr;

    logic               r_v1, r_v2, r_v3, r_v4;
    logic [RW-1:0]      r_r1, r_r2;
    logic [SMP_W-1:0]   r_smp_rd;
    logic [WIN_W-1:0]   r_win_rd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] vsum;
    logic signed [V_W-1:0]    r_v;
    logic signed [TW_W-1:0]   r_cos, r_sin;
    logic signed [TAP_W-1:0]  r_pre, r_pim;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic signed [ACC_W-1:0]  acc_re_rnd, acc_im_rnd;
    logic signed [RND_W-1:0]  re_r, im_r;
    logic signed [2*RND_W-1:0] sq_re_full, sq_im_full;
    logic [RAD_W-1:0]         r_sq_re, r_sq_im;
    logic [RAD_W-1:0]         r_rad, r_root, r_bit;
    logic [RAD_W-1:0]         trial;
    logic [ROOT_W:0]          mag_full;
    logic [MAG_W-1:0]         mag_sat;
    logic                     r_out_valid;
    logic [BIN_W-1:0]         r_out_bin;
    logic [MAG_W-1:0]         r_out_mag;
    logic                     r_out_last;

    assign addr_sum = {1'b0, r_wp} + {1'b0, i_n};
    assign rd_addr  = (addr_sum >= (RW+1)'(FRAME_SIZE)) ?
                      RW'(addr_sum - (RW+1)'(FRAME_SIZE)) : addr_sum[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_we) begin
            smp_mem[r_wp] <= i_sample;
        end
        if (i_cmd.win_we) begin
            win_mem[i_win_index] <= i_win_value;
        end
        r_smp_rd <= smp_mem[rd_addr];
        r_win_rd <= win_mem[WIN_IDX_W'(i_n)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_cmd.smp_we) begin
            r_wp <= (r_wp == RW'(FRAME_SIZE - 1)) ? '0 : r_wp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign vsum = r_prod + PROD_W'(16384);

    always_ff @(posedge i_clk) begin
        r_r1   <= i_r;
        r_r2   <= r_r1;
        r_prod <= $signed(r_smp_rd) * $signed({1'b0, r_win_rd});
        r_v    <= V_W'(vsum >>> 15);
        r_cos  <= cos_tab[r_r2];
        r_sin  <= sin_tab[r_r2];
        r_pre  <= r_v * r_cos;
        r_pim  <= r_v * r_sin;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v4) begin
            r_acc_re <= r_acc_re + ACC_W'(r_pre);
            r_acc_im <= r_acc_im - ACC_W'(r_pim);
        end
    end

    assign acc_re_rnd = (r_acc_re + ACC_W'(16384)) >>> 15;
    assign acc_im_rnd = (r_acc_im + ACC_W'(16384)) >>> 15;
    assign re_r       = RND_W'(acc_re_rnd);
    assign im_r       = RND_W'(acc_im_rnd);
    assign sq_re_full = re_r * re_r;
    assign sq_im_full = im_r * im_r;
    assign trial      = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_sq_re <= RAD_W'(sq_re_full);
            r_sq_im <= RAD_W'(sq_im_full);
        end
        if (i_cmd.rad_load) begin
            r_rad  <= r_sq_re + r_sq_im;
            r_root <= '0;
            r_bit  <= RAD_W'(1) << (RAD_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_rad >= trial) begin
                r_rad  <= r_rad - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign mag_full = {1'b0, r_root[ROOT_W-1:0]} + (ROOT_W+1)'(r_rad > r_root);
    assign mag_sat  = (mag_full > (ROOT_W+1)'(MAG_MAX)) ? MAG_W'(MAG_MAX) : MAG_W'(mag_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_bin  <= i_cmd.bin;
            r_out_mag  <= mag_sat;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = {(M_TDATA_W - BIN_W - MAG_W)'(0), r_out_mag, r_out_bin};
    assign o_m_tlast       = r_out_last;

endmodule

// ===== rtl/stft_ctrl.sv =====
// ----------------------------------------------------------------------------
// stft_ctrl
// Frame counting, hop register and bin/tap sequencing of the spectrogram unit.
// ----------------------------------------------------------------------------
module stft_ctrl #(
    parameter int FRAME_SIZE = stft_pkg::FRAME_SIZE_DEF,
    parameter int RW         = $clog2(FRAME_SIZE)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic                       i_func,
    input  logic                       i_start_req,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [stft_pkg::HOP_W-1:0] i_cfg_data,
    output stft_pkg::t_cmd             o_cmd,
    input  stft_pkg::t_sts             i_sts,
    output logic [RW-1:0]              o_n,
    output logic [RW-1:0]              o_r
);
    import stft_pkg::*;

    localparam int KW = $clog2(FRAME_SIZE / 2 + 1);

    t_state r_state, n_state;
    logic [HOP_W-1:0]  r_hop_size;
    logic [CNT_W-1:0]  r_fill, r_hop;
    logic [CNT_W-1:0]  fill_base, hop_base, fill_inc, hop_inc, hop_eff;
    logic [KW-1:0]     r_k;
    logic [RW-1:0]     r_n, r_r;
    logic [RW:0]       k_sum;
    logic [STEP_W-1:0] r_step;
    logic              accept, smp_acc, trigger, last_bin;

    assign accept    = i_s_tvalid && o_s_tready;
    assign smp_acc   = accept && !i_func;
    assign fill_base = i_start_req ? '0 : r_fill;
    assign hop_base  = i_start_req ? '0 : r_hop;
    assign fill_inc  = fill_base + 1'b1;
    assign hop_inc   = hop_base + 1'b1;
    assign hop_eff   = (r_hop_size == '0) ? CNT_W'(1) : r_hop_size;
    assign trigger   = smp_acc && ((fill_base < CNT_W'(FRAME_SIZE)) ?
                       (fill_inc == CNT_W'(FRAME_SIZE)) : (hop_inc >= hop_eff));
    assign last_bin  = (r_k == KW'(FRAME_SIZE / 2));
    assign k_sum     = {1'b0, r_r} + (RW+1)'(r_k);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (trigger) n_state = S_ISSUE;
            S_ISSUE: if (r_n == RW'(FRAME_SIZE - 1)) n_state = S_DRAIN;
            S_DRAIN: if (!i_sts.pipe_busy) n_state = S_SQ;
            S_SQ:    n_state = S_RAD;
            S_RAD:   n_state = S_SQRT;
            S_SQRT:  if (r_step == STEP_W'(SQRT_STEPS - 1)) n_state = S_EMIT;
            S_EMIT:  if (i_sts.out_free) n_state = last_bin ? S_IDLE : S_ISSUE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.win_we    = accept && i_func;
        o_cmd.smp_we    = smp_acc;
        o_cmd.issue     = (r_state == S_ISSUE);
        o_cmd.acc_clr   = (r_state == S_ISSUE) && (r_n == '0);
        o_cmd.sq_load   = (r_state == S_SQ);
        o_cmd.rad_load  = (r_state == S_RAD);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.out_load  = (r_state == S_EMIT) && i_sts.out_free;
        o_cmd.out_last  = last_bin;
        o_cmd.bin       = BIN_W'(r_k);
        o_s_tready      = (r_state == S_IDLE);
        o_cfg_ready     = 1'b1;
        o_n             = r_n;
        o_r             = r_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hop_size <= HOP_RESET;
            r_fill     <= '0;
            r_hop      <= '0;
            r_k        <= '0;
            r_n        <= '0;
            r_r        <= '0;
            r_step     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_hop_size <= i_cfg_data;
            end
            if (smp_acc) begin
                if (fill_base < CNT_W'(FRAME_SIZE)) begin
                    r_fill <= fill_inc;
                    r_hop  <= (fill_inc == CNT_W'(FRAME_SIZE)) ? '0 : hop_base;
                end else begin
                    r_fill <= fill_base;
                    r_hop  <= (hop_inc >= hop_eff) ? '0 : hop_inc;
                end
            end
            case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    r_n <= '0;
                    r_r <= '0;
                end
                S_ISSUE: begin
                    r_n <= r_n + 1'b1;
                    r_r <= (k_sum >= (RW+1)'(FRAME_SIZE)) ?
                           RW'(k_sum - (RW+1)'(FRAME_SIZE)) : k_sum[RW-1:0];
                end
                S_RAD: r_step <= '0;
                S_SQRT: r_step <= r_step + 1'b1;
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_k <= r_k + 1'b1;
                        r_n <= '0;
                        r_r <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the spectrogram unit: loads the window, streams samples with
// random idling on both sides, predicts every bin magnitude in software and
// compares each master transaction with the oldest predicted bin.
// ----------------------------------------------------------------------------
module tb;
    import stft_pkg::*;

    localparam int NPT     = 64;
    localparam int NBINS   = NPT / 2 + 1;
    localparam int LIMIT   = 2000000;
    localparam int SETTLE  = 50;
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_WIN    = 1'b1;

    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
        logic             last;
    } t_bin_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic [S_TUSER_W-1:0] i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [HOP_W-1:0]     i_cfg_data;

    t_bin_result    pending_bins[$];
    int             errors;
    int             cycles;
    bit             no_idle;

    int             cos_q15[NPT];
    int             sin_q15[NPT];
    logic [15:0]    history[NPT];
    logic [15:0]    window_coef[64];
    int             fill_cnt;
    int             hop_cnt;
    int             hop_len;

    stft_magnitude_spectrogram_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // sample[15:0], win_index[21:16], win_value[37:22]
        .i_s_tuser   (i_s_tuser),   // func[0], start_req[1]
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // bin_index[5:0], magnitude[27:6]
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int q30_clamp_q15(longint s);
        if (s < 0) s = 0;
        if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
        return int'((s + 16384) >>> 15);
    endfunction

    function automatic void build_twiddles();
        longint unsigned x, x2, ts, tc;
        longint          ss, cs;
        int              q, rem, s, c;
        for (int r = 0; r < NPT; r++) begin
            q   = (4 * r) / NPT;
            rem = 4 * r - q * NPT;
            x   = (64'd1686629713 * rem) / NPT;
            x2  = (x * x) >> 30;
            ts  = x;
            tc  = 64'd1 << 30;
            ss  = longint'(x);
            cs  = longint'(tc);
            for (int i = 1; i <= 7; i++) begin
                ts = ((ts * x2) >> 30) / ((2 * i) * (2 * i + 1));
                tc = ((tc * x2) >> 30) / ((2 * i - 1) * (2 * i));
                if (i % 2 == 1) begin
                    ss -= longint'(ts);
                    cs -= longint'(tc);
                end else begin
                    ss += longint'(ts);
                    cs += longint'(tc);
                end
            end
            s = q30_clamp_q15(ss);
            c = q30_clamp_q15(cs);
            case (q)
                0: begin cos_q15[r] = c;  sin_q15[r] = s;  end
                1: begin cos_q15[r] = -s; sin_q15[r] = c;  end
                2: begin cos_q15[r] = -c; sin_q15[r] = -s; end
                default: begin cos_q15[r] = s; sin_q15[r] = -c; end
            endcase
        end
    endfunction

    function automatic longint round_q15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint unsigned root_rounded(longint unsigned n);
        longint unsigned res, bitv, m;
        res  = 0;
        bitv = 64'd1 << 62;
        m    = n;
        while (bitv > m) bitv >>= 2;
        while (bitv != 0) begin
            if (m >= res + bitv) begin
                m   = m - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        if (n - res * res > res) res++;
        return res;
    endfunction

    function automatic void predict_frame_bins();
        longint          v[NPT];
        longint          re, im;
        longint unsigned mag;
        t_bin_result     item;
        for (int n = 0; n < NPT; n++)
            v[n] = round_q15(longint'($signed(history[n])) * longint'(window_coef[n]));
        for (int k = 0; k < NBINS; k++) begin
            re = 0;
            im = 0;
            for (int n = 0; n < NPT; n++) begin
                re += v[n] * cos_q15[(k * n) % NPT];
                im -= v[n] * sin_q15[(k * n) % NPT];
            end
            re  = round_q15(re);
            im  = round_q15(im);
            mag = root_rounded(longint'(re * re) + longint'(im * im));
            if (mag > 64'd4194303) mag = 64'd4194303;
            item.bin  = BIN_W'(k);
            item.mag  = MAG_W'(mag);
            item.last = (k == NPT / 2);
            pending_bins.push_back(item);
        end
    endfunction

    function automatic void spectrum_predict(logic func, logic start, logic [15:0] smp,
                                             logic [5:0] idx, logic [15:0] val);
        int hop;
        hop = (hop_len == 0) ? 1 : hop_len;
        if (func == FUNC_WIN) begin
            window_coef[idx] = val;
            return;
        end
        if (start) begin
            fill_cnt = 0;
            hop_cnt  = 0;
        end
        for (int n = 0; n < NPT - 1; n++) history[n] = history[n + 1];
        history[NPT - 1] = smp;
        if (fill_cnt < NPT) begin
            fill_cnt++;
            if (fill_cnt == NPT) begin
                hop_cnt = 0;
                predict_frame_bins();
            end
            return;
        end
        hop_cnt = (hop_cnt + 1) & 8'h7F;
        if (hop_cnt >= hop) begin
            hop_cnt = 0;
            predict_frame_bins();
        end
    endfunction

    task automatic send_item(logic func, logic start, logic [15:0] smp,
                             logic [5:0] idx, logic [15:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= {start, func};
        i_s_tdata  <= {2'b00, val, idx, smp};
        do @(posedge i_clk); while (!o_s_tready);
        spectrum_predict(func, start, smp, idx, val);
    endtask

    task automatic send_sample(logic start, logic [15:0] smp);
        send_item(FUNC_SAMPLE, start, smp, 6'($urandom), 16'($urandom));
    endtask

    task automatic send_window(logic [5:0] idx, logic [15:0] val);
        send_item(FUNC_WIN, 1'($urandom), 16'($urandom), idx, val);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_hop(logic [HOP_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hop_len = value;
    endtask

    task automatic test_window_load();
        for (int i = 0; i < 64; i++) begin
            if (i == 0) send_window(6'(i), 16'd32768);
            else if (i == 63) send_window(6'(i), 16'd0);
            else send_window(6'(i), 16'($urandom_range(0, 32768)));
        end
    endtask

    task automatic test_extremes();
        for (int i = 0; i < NPT; i++)
            send_sample(i == 0, (i % 2) ? 16'h7FFF : 16'h8000);
        write_hop(7'd1);
        send_sample(1'b0, 16'h0000);
        send_window(6'd63, 16'd32768);
        send_sample(1'b0, 16'h7FFF);
        write_hop(7'd0);
        send_sample(1'b0, 16'h8000);
    endtask

    task automatic test_window_overrange();
        send_window(6'd0, 16'hFFFF);
        send_window(6'd1, 16'hFFFF);
        send_sample(1'b0, 16'h8000);
    endtask

    task automatic test_long_hop();
        write_hop(7'd64);
        for (int i = 0; i < 3; i++) begin
            if (i == 1) drain_results();
            send_sample(1'b0, 16'($urandom));
        end
    endtask

    task automatic test_random_stream();
        write_hop(7'd2);
        for (int i = 0; i < 6; i++) begin
            no_idle = (i >= 2 && i < 4);
            if ($urandom_range(0, 5) == 0)
                send_window(6'($urandom), 16'($urandom_range(0, 32768)));
            else
                send_sample($urandom_range(0, 24) == 0, 16'($urandom));
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_bin_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected bin: got bin %0d mag %0d last %0b", $time,
                         o_m_tdata[5:0], o_m_tdata[27:6], o_m_tlast);
                errors++;
            end else begin
                want = pending_bins.pop_front();
                if (o_m_tdata[5:0] !== want.bin) begin
                    $display("%0t: bin_index expected %0d actual %0d", $time,
                             want.bin, o_m_tdata[5:0]);
                    errors++;
                end
                if (o_m_tdata[27:6] !== want.mag) begin
                    $display("%0t: magnitude expected %0d actual %0d", $time,
                             want.mag, o_m_tdata[27:6]);
                    errors++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: frame_last expected %0b actual %0b", $time,
                             want.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        errors      = 0;
        no_idle     = 1'b0;
        fill_cnt    = 0;
        hop_cnt     = 0;
        hop_len     = 16;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        build_twiddles();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_window_load();
        test_extremes();
        test_window_overrange();
        test_long_hop();
        test_random_stream();
        drain_results();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== stft_magnitude_spectrogram_unit.f =====
rtl/stft_pkg.sv
rtl/stft_dp.sv
rtl/stft_ctrl.sv
rtl/stft_magnitude_spectrogram_unit.sv
test/tb.sv
